### rtl/core/wsfe_pkg.sv
// ----------------------------------------------------------------------------
// wsfe_pkg
// Types, codes and constants shared by the websocket frame encoder files.
// ----------------------------------------------------------------------------
package wsfe_pkg;

	localparam int LEN_W = 63;

	localparam logic       ACT_START   = 1'b0;
	localparam logic       ACT_PAYLOAD = 1'b1;

	localparam logic [31:0] MASK_KEY_RESET = 32'h1234_5678;

	localparam logic [7:0] TYPE_TEXT_FINAL = 8'd129;
	localparam logic [7:0] MASK_BIT        = 8'h80;
	localparam logic [7:0] LEN_CODE_16     = 8'd126;
	localparam logic [7:0] LEN_CODE_64     = 8'd127;
	localparam logic [LEN_W-1:0] LEN_SHORT_MAX = LEN_W'(125);
	localparam logic [LEN_W-1:0] LEN_MID_MAX   = LEN_W'(65535);

	// index of the final header byte for each length form
	localparam logic [3:0] HDR_LAST_SHORT = 4'd5;
	localparam logic [3:0] HDR_LAST_MID   = 4'd7;
	localparam logic [3:0] HDR_LAST_LONG  = 4'd13;

	typedef enum logic [1:0] {
		FORM_SHORT,
		FORM_MID,
		FORM_LONG
	} len_form_t;

	typedef struct packed {
		logic             action;
		logic [7:0]       frame_type;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       payload_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} word_t;

	typedef struct packed {
		logic [3:0] hdr_idx;
		logic       rem_zero;
	} core_status_t;

	// most significant key byte goes with position 0
	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			2'd3: b = key[7:0];
			default: b = key[7:0];
		endcase
		return b;
	endfunction

endpackage

### rtl/core/wsfe_if.sv
// ----------------------------------------------------------------------------
// wsfe_if
// Handshake channels of the websocket frame encoder: items, frame words, config.
// ----------------------------------------------------------------------------
interface wsfe_item_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [7:0]                frame_type;
	logic [wsfe_pkg::LEN_W-1:0] frame_length;
	logic [7:0]                payload_byte;

	modport source (output valid, action, frame_type, frame_length, payload_byte,
		input ready);
	modport sink (input valid, action, frame_type, frame_length, payload_byte,
		output ready);
endinterface

interface wsfe_word_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

interface wsfe_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/core/wsfe_in_stage.sv
// ----------------------------------------------------------------------------
// wsfe_in_stage
// Input register; holds one item until the core has finished with it.
// ----------------------------------------------------------------------------
module wsfe_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wsfe_pkg::item_t in_item,
	input  logic            pop,
	output logic            valid_s1,
	output wsfe_pkg::item_t item_s1
);
	import wsfe_pkg::*;

	assign in_ready = !valid_s1 || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/core/wsfe_core.sv
// ----------------------------------------------------------------------------
// wsfe_core
// Header sequencer, payload masking and frame state.
// ----------------------------------------------------------------------------
module wsfe_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  wsfe_pkg::item_t        item_s1,
	input  logic [31:0]            mask_key,
	input  logic                   out_free,
	output logic                   pop,
	output logic                   emit_valid,
	output wsfe_pkg::word_t        emit_word,
	output wsfe_pkg::core_status_t status
);
	import wsfe_pkg::*;

	logic [LEN_W-1:0] rem_q, rem_n;
	logic [1:0]       kpos_q, kpos_n;
	logic [3:0]       idx_q, idx_n;

	len_form_t        form;
	logic [3:0]       last_idx;
	logic [7:0]       hdr_byte;
	logic [LEN_W:0]   len64;
	logic [3:0]       idx_m2, idx_m4, idx_m10, byte_sel;
	logic [LEN_W-1:0] len;

	assign len     = item_s1.frame_length;
	assign len64   = {1'b0, len};
	assign idx_m2  = idx_q - 4'd2;
	assign idx_m4  = idx_q - 4'd4;
	assign idx_m10 = idx_q - 4'd10;
	assign byte_sel = 4'd9 - idx_q;

	always_comb begin
		if (len <= LEN_SHORT_MAX) begin
			form = FORM_SHORT;
		end else if (len <= LEN_MID_MAX) begin
			form = FORM_MID;
		end else begin
			form = FORM_LONG;
		end
	end

	always_comb begin
		case (form)
			FORM_SHORT: last_idx = HDR_LAST_SHORT;
			FORM_MID:   last_idx = HDR_LAST_MID;
			FORM_LONG:  last_idx = HDR_LAST_LONG;
			default:    last_idx = HDR_LAST_LONG;
		endcase
	end

	always_comb begin
		hdr_byte = 8'd0;
		if (idx_q == 4'd0) begin
			hdr_byte = (item_s1.frame_type == 8'd0) ? TYPE_TEXT_FINAL : item_s1.frame_type;
		end else if (idx_q == 4'd1) begin
			case (form)
				FORM_SHORT: hdr_byte = MASK_BIT | {1'b0, len[6:0]};
				FORM_MID:   hdr_byte = MASK_BIT | LEN_CODE_16;
				FORM_LONG:  hdr_byte = MASK_BIT | LEN_CODE_64;
				default:    hdr_byte = MASK_BIT | LEN_CODE_64;
			endcase
		end else begin
			case (form)
				FORM_SHORT: hdr_byte = key_byte(mask_key, idx_m2[1:0]);
				FORM_MID: begin
					if (idx_q == 4'd2) begin
						hdr_byte = len[15:8];
					end else if (idx_q == 4'd3) begin
						hdr_byte = len[7:0];
					end else begin
						hdr_byte = key_byte(mask_key, idx_m4[1:0]);
					end
				end
				FORM_LONG: begin
					// extended length, big-endian
					if (idx_q <= 4'd9) begin
						hdr_byte = len64[{byte_sel[2:0], 3'b000} +: 8];
					end else begin
						hdr_byte = key_byte(mask_key, idx_m10[1:0]);
					end
				end
				default: hdr_byte = 8'd0;
			endcase
		end
	end

	always_comb begin
		pop        = 1'b0;
		emit_valid = 1'b0;
		emit_word  = '0;
		rem_n      = rem_q;
		kpos_n     = kpos_q;
		idx_n      = idx_q;
		if (valid_s1) begin
			if (item_s1.action == ACT_PAYLOAD) begin
				if (rem_q == '0) begin
					// excess payload is dropped
					pop = 1'b1;
				end else if (out_free) begin
					pop                = 1'b1;
					emit_valid         = 1'b1;
					emit_word.out_byte = item_s1.payload_byte ^ key_byte(mask_key, kpos_q);
					emit_word.last     = (rem_q == LEN_W'(1));
					rem_n              = rem_q - LEN_W'(1);
					kpos_n             = kpos_q + 2'd1;
				end
			end else if (out_free) begin
				emit_valid         = 1'b1;
				emit_word.out_byte = hdr_byte;
				emit_word.last     = (idx_q == last_idx) && (len == '0);
				if (idx_q == last_idx) begin
					pop    = 1'b1;
					idx_n  = 4'd0;
					rem_n  = len;
					kpos_n = 2'd0;
				end else begin
					idx_n = idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			kpos_q <= 2'd0;
			idx_q  <= 4'd0;
		end else begin
			rem_q  <= rem_n;
			kpos_q <= kpos_n;
			idx_q  <= idx_n;
		end
	end

	assign status.hdr_idx  = idx_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

### rtl/core/wsfe_out_stage.sv
// ----------------------------------------------------------------------------
// wsfe_out_stage
// Output register for encoded frame words.
// ----------------------------------------------------------------------------
module wsfe_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_valid,
	input  wsfe_pkg::word_t load_word,
	output logic            free,
	output logic            out_valid,
	input  logic            out_ready,
	output wsfe_pkg::word_t out_word
);
	import wsfe_pkg::*;

	logic  valid_q;
	word_t word_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load_valid) begin
			word_q <= load_word;
		end
	end

endmodule

### rtl/core/websocket_frame_encoder.sv
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// Masked client-side websocket frame encoder, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// A payload item gives one masked byte; a payload item past the announced
// length is dropped with no word. A start item occupies the header sequencer
// for 6, 8 or 14 header bytes (7-bit, 16-bit or 64-bit length form), one header
// byte per cycle while the single output register is free. Items pass through
// the input and output registers. The mask key register is read live and should
// be written only while the block is idle; cfg.ready is always high.
module websocket_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	wsfe_item_if.sink   item,
	wsfe_word_if.source frame,
	wsfe_cfg_if.sink    cfg
);
	import wsfe_pkg::*;

	logic [31:0]  mask_key_q;
	item_t        in_item;
	item_t        item_s1;
	logic         valid_s1;
	logic         pop;
	logic         out_free;
	logic         emit_valid;
	word_t        emit_word;
	word_t        out_word;
	core_status_t status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_key_q <= MASK_KEY_RESET;
		end else if (cfg.valid) begin
			mask_key_q <= cfg.data;
		end
	end

	assign in_item.action       = item.action;
	assign in_item.frame_type   = item.frame_type;
	assign in_item.frame_length = item.frame_length;
	assign in_item.payload_byte = item.payload_byte;

	wsfe_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_item  (in_item),
		.pop      (pop),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsfe_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.mask_key   (mask_key_q),
		.out_free   (out_free),
		.pop        (pop),
		.emit_valid (emit_valid),
		.emit_word  (emit_word),
		.status     (status)
	);

	wsfe_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (emit_valid),
		.load_word  (emit_word),
		.free       (out_free),
		.out_valid  (frame.valid),
		.out_ready  (frame.ready),
		.out_word   (out_word)
	);

	assign frame.out_byte = out_word.out_byte;
	assign frame.last     = out_word.last;

`ifndef SYNTHESIS
	// header index never runs past the long form
	assert property (@(posedge clk) disable iff (!arst_n) status.hdr_idx <= HDR_LAST_LONG)
		else $error("header index out of range");

	// mid-header implies a start item is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		status.hdr_idx != 4'd0 |-> valid_s1 && item_s1.action == ACT_START)
		else $error("header sequencer running without a start item");

	// a word marked last closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_free && emit_valid && emit_word.last |=> status.rem_zero)
		else $error("last word issued with payload still expected");

	// the item register only drains when the core pops it
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !pop |=> valid_s1 && $stable(item_s1))
		else $error("held item lost before completion");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start and payload items into the websocket frame encoder with random
// bursts and receiver stalls, predicts every header and masked payload byte on
// the wire, and checks each output word and its last flag in order.
// ----------------------------------------------------------------------------
module testbench;
	import wsfe_pkg::*;

	localparam int STALL_LIMIT = 4000;

	class frame_scoreboard;
		logic [31:0]      key;
		logic [LEN_W-1:0] left;
		logic [1:0]       kpos;
		word_t            wire_bytes[$];
		int               mismatches;
		int               words_seen;

		function new();
			key = MASK_KEY_RESET;
			left = '0;
			kpos = '0;
			mismatches = 0;
			words_seen = 0;
		endfunction

		function logic [7:0] key_at(input logic [1:0] pos);
			logic [31:0] s;
			s = key << (8 * pos);
			return s[31:24];
		endfunction

		function void push(input logic [7:0] b, input logic fin);
			word_t w;
			w.out_byte = b;
			w.last = fin;
			wire_bytes.push_back(w);
		endfunction

		function int pending();
			return wire_bytes.size();
		endfunction

		function void note_item(input item_t it);
			logic [LEN_W-1:0] len;
			logic [LEN_W-1:0] sh;
			if (it.action == ACT_START) begin
				len = it.frame_length;
				push((it.frame_type == 8'd0) ? TYPE_TEXT_FINAL : it.frame_type, 1'b0);
				if (len <= LEN_SHORT_MAX) begin
					push(MASK_BIT | len[7:0], 1'b0);
				end else if (len <= LEN_MID_MAX) begin
					push(MASK_BIT | LEN_CODE_16, 1'b0);
					push(len[15:8], 1'b0);
					push(len[7:0], 1'b0);
				end else begin
					push(MASK_BIT | LEN_CODE_64, 1'b0);
					for (int i = 7; i >= 0; i--) begin
						sh = len >> (8 * i);
						push(sh[7:0], 1'b0);
					end
				end
				// an empty frame ends on the last key byte
				for (int i = 0; i < 4; i++)
					push(key_at(i[1:0]), (i == 3) && (len == '0));
				left = len;
				kpos = '0;
			end else if (left != '0) begin
				left = left - 1'b1;
				push(it.payload_byte ^ key_at(kpos), left == '0);
				kpos = kpos + 1'b1;
			end
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("mismatch at word %0d: %s", words_seen, msg);
		endtask

		task check_word(input word_t got);
			word_t want;
			words_seen++;
			if (wire_bytes.size() == 0) begin
				report($sformatf("unexpected word %02h last %0b", got.out_byte, got.last));
				return;
			end
			want = wire_bytes.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("byte %02h, want %02h", got.out_byte, want.out_byte));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b", got.last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	frame_scoreboard sb;
	int  burst_left;
	bit  item_up;
	bit  hold_req;
	bit  hold_done;
	int  idle_cycles;

	wsfe_item_if item_ch ();
	wsfe_word_if word_ch ();
	wsfe_cfg_if  cfg_ch ();

	websocket_frame_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.frame  (word_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (item_ch.valid && item_ch.ready)
			sb.note_item({item_ch.action, item_ch.frame_type, item_ch.frame_length,
				item_ch.payload_byte});
		if (word_ch.valid && word_ch.ready)
			sb.check_word({word_ch.out_byte, word_ch.last});
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (word_ch.valid && word_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: stall pattern rotates through four modes, plus one long hold-off
	initial begin
		int unsigned rx_cycle;
		rx_cycle = 0;
		word_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				word_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				rx_cycle++;
				case (rx_cycle[7:6])
					2'd0: word_ch.ready <= 1'b1;
					2'd1: word_ch.ready <= 1'($urandom_range(0, 1));
					2'd2: word_ch.ready <= ($urandom_range(0, 3) == 0);
					default: word_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic item_t start_item(input logic [7:0] ftype, input logic [LEN_W-1:0] len);
		item_t it;
		it.action = ACT_START;
		it.frame_type = ftype;
		it.frame_length = len;
		it.payload_byte = 8'($urandom);
		return it;
	endfunction

	function automatic item_t payload_item(input logic [7:0] b);
		item_t it;
		it.action = ACT_PAYLOAD;
		it.frame_type = 8'($urandom);
		it.frame_length = LEN_W'({$urandom, $urandom});
		it.payload_byte = b;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		item_ch.valid <= 1'b1;
		item_ch.action <= it.action;
		item_ch.frame_type <= it.frame_type;
		item_ch.frame_length <= it.frame_length;
		item_ch.payload_byte <= it.payload_byte;
		item_up = 1'b1;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			item_up = 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// wait until every expected word is out and dropped items have drained
	task automatic settle();
		if (item_up) begin
			item_ch.valid <= 1'b0;
			item_up = 1'b0;
		end
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_key(input logic [31:0] k);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= k;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		sb.key = k;
	endtask

	task automatic run_frames(input int budget);
		int               counted;
		int               kind;
		int               n_pay;
		logic [7:0]       ftype;
		logic [LEN_W-1:0] len;
		counted = 0;
		while (counted < budget) begin
			kind = $urandom_range(0, 19);
			if (kind == 17) begin
				// stray payload word, dropped or taken into an open frame
				send_item(payload_item(8'($urandom_range(0, 255))));
			end else begin
				ftype = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
				if (kind <= 13)
					len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(13, 125))
						: LEN_W'($urandom_range(0, 12));
				else if (kind <= 15)
					len = ($urandom_range(0, 3) == 0) ? LEN_MID_MAX
						: LEN_W'($urandom_range(126, 65535));
				else if (kind == 16) begin
					len = LEN_W'({$urandom, $urandom});
					len = len >> $urandom_range(0, 40);
					if (len <= LEN_MID_MAX)
						len[16] = 1'b1;
				end else
					len = LEN_W'($urandom_range(0, 10));
				if (kind <= 13)
					n_pay = int'(len);
				else if (kind <= 16)
					n_pay = $urandom_range(0, 8);
				else if (kind == 18)
					n_pay = $urandom_range(0, int'(len));
				else
					n_pay = int'(len) + $urandom_range(1, 3);
				send_item(start_item(ftype, len));
				counted++;
				for (int i = 0; i < n_pay; i++) begin
					send_item(payload_item(8'($urandom_range(0, 255))));
					if (i < len)
						counted++;
				end
			end
		end
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		item_up = 1'b0;
		burst_left = $urandom_range(1, 40);
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_START;
		item_ch.frame_type <= 8'd0;
		item_ch.frame_length <= '0;
		item_ch.payload_byte <= 8'd0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty text frame, then a payload word with no frame open
		send_item(start_item(8'd0, '0));
		send_item(payload_item(8'hA5));
		send_item(start_item(8'h82, LEN_W'(3)));
		send_item(payload_item(8'h00));
		send_item(payload_item(8'hFF));
		send_item(payload_item(8'h5A));
		send_item(payload_item(8'h11));
		// largest short length, abandoned by the next start
		send_item(start_item(8'hFF, LEN_SHORT_MAX));
		send_item(payload_item(8'h3C));
		send_item(start_item(8'h01, LEN_W'(126)));
		send_item(payload_item(8'h81));
		send_item(start_item(8'h88, LEN_MID_MAX));
		send_item(start_item(8'h89, LEN_MID_MAX + 1'b1));
		send_item(start_item(8'h8A, {LEN_W{1'b1}}));
		// key position wraps within this frame
		send_item(start_item(8'h80, LEN_W'(5)));
		send_item(payload_item(8'h01));
		send_item(payload_item(8'h02));
		send_item(payload_item(8'h80));
		send_item(payload_item(8'h40));
		send_item(payload_item(8'hFE));

		write_key(32'h0000_0000);
		hold_req = 1'b1;
		run_frames(20);
		write_key(32'hFFFF_FFFF);
		run_frames(20);
		repeat (3) begin
			write_key($urandom);
			run_frames(15);
		end
		settle();
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
